// ===== sv/lru_page_cache_controller_assert.svh =====
// ----------------------------------------------------------------------------
// LRU page cache controller assertion macros
// Concurrent checks that vanish when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef LRU_PAGE_CACHE_CONTROLLER_ASSERT_SVH
`define LRU_PAGE_CACHE_CONTROLLER_ASSERT_SVH
`ifndef SYNTHESIS
`define LPC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lru_page_cache_controller: same-cycle check failed");
`define LPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lru_page_cache_controller: next-cycle check failed");
`else
`define LPC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define LPC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/lpc_pkg.sv =====
// ----------------------------------------------------------------------------
// LRU page cache controller package
// Shared widths, codes and the word formats passed between the parts.
// ----------------------------------------------------------------------------
`default_nettype none

package lpc_pkg;

    localparam int FRAME_COUNT_DEF = 4;
    localparam int INDEX_BITS_DEF  = 24;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam int PAGE_WORDS = 256;
    localparam int OFFS_W     = $clog2(PAGE_WORDS);
    localparam int TAG_W      = 16;
    localparam int COUNT_W    = 32;

    localparam logic OP_ACCESS = 1'b0;
    localparam logic OP_FLUSH  = 1'b1;

    typedef struct packed {
        logic              flush;
        logic [TAG_W-1:0]  page;
        logic [OFFS_W-1:0] offset;
    } cmd_t;

    typedef struct packed {
        logic               last;
        logic               hit;
        logic [OFFS_W-1:0]  page_offset;
        logic               load_request;
        logic [TAG_W-1:0]   load_page;
        logic               writeback_request;
        logic [TAG_W-1:0]   writeback_page;
        logic [COUNT_W-1:0] hit_count;
        logic [COUNT_W-1:0] fault_count;
    } res_t;

endpackage

`default_nettype wire

// ===== sv/lru_page_cache_controller.sv =====
// ----------------------------------------------------------------------------
// LRU page cache controller
// Control side of a fully associative page cache with least recently used
// replacement and write-back requests.
//
//   Channel   Handshake      Word
//   input     push / full    op, element_index
//   result    pop / empty    last, hit, frame_slot, page_offset, load_request,
//                            load_page, writeback_request, writeback_page,
//                            hit_count, fault_count
//
// An access gives one result word from the back end and a flush gives one per
// frame, stepping through the frames in order; last marks the final word.
// A command is registered in the command queue and its result word in the
// result queue before it reaches the result ports.
// Both queues hold QUEUE_DEPTH words; full rises when the command queue is full,
// and the back end waits while the result queue is full.
// After reset frame i holds page i, all frames are clean and both queues are empty.
// ----------------------------------------------------------------------------
`default_nettype none
`include "lru_page_cache_controller_assert.svh"

module lru_page_cache_controller #(
    parameter int FRAME_COUNT = lpc_pkg::FRAME_COUNT_DEF,
    parameter int INDEX_BITS  = lpc_pkg::INDEX_BITS_DEF,
    parameter int QUEUE_DEPTH = lpc_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           push,
    output logic                                full,
    input  wire logic                           op,
    input  wire logic [INDEX_BITS-1:0]          element_index,
    output logic                                empty,
    input  wire logic                           pop,
    output logic                                last,
    output logic                                hit,
    output logic [$clog2(FRAME_COUNT)-1:0]      frame_slot,
    output logic [lpc_pkg::OFFS_W-1:0]          page_offset,
    output logic                                load_request,
    output logic [lpc_pkg::TAG_W-1:0]           load_page,
    output logic                                writeback_request,
    output logic [lpc_pkg::TAG_W-1:0]           writeback_page,
    output logic [lpc_pkg::COUNT_W-1:0]         hit_count,
    output logic [lpc_pkg::COUNT_W-1:0]         fault_count
);

    localparam int SLOT_W = $clog2(FRAME_COUNT);
    localparam int RES_W  = $bits(lpc_pkg::res_t);
    localparam int WORD_W = RES_W + SLOT_W;

    lpc_pkg::cmd_t      cmd;
    logic               cmd_valid;
    logic               cmd_take;
    logic               res_full;
    logic               res_valid;
    lpc_pkg::res_t      res;
    logic [SLOT_W-1:0]  res_slot;
    logic [WORD_W-1:0]  res_word_in;
    logic [WORD_W-1:0]  res_word_out;
    lpc_pkg::res_t      res_out;

    lpc_front #(
        .INDEX_BITS  (INDEX_BITS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .op            (op),
        .element_index (element_index),
        .cmd           (cmd),
        .cmd_valid     (cmd_valid),
        .cmd_take      (cmd_take)
    );

    lpc_back #(
        .FRAME_COUNT (FRAME_COUNT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take),
        .res_full  (res_full),
        .res_valid (res_valid),
        .res       (res),
        .res_slot  (res_slot)
    );

    assign res_word_in = {res_slot, res};

    lpc_fifo #(
        .WIDTH (WORD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_valid),
        .wr_data (res_word_in),
        .full    (res_full),
        .pop     (pop),
        .rd_data (res_word_out),
        .empty   (empty)
    );

    assign res_out           = lpc_pkg::res_t'(res_word_out[RES_W-1:0]);
    assign frame_slot        = res_word_out[RES_W +: SLOT_W];
    assign last              = res_out.last;
    assign hit               = res_out.hit;
    assign page_offset       = res_out.page_offset;
    assign load_request      = res_out.load_request;
    assign load_page         = res_out.load_page;
    assign writeback_request = res_out.writeback_request;
    assign writeback_page    = res_out.writeback_page;
    assign hit_count         = res_out.hit_count;
    assign fault_count       = res_out.fault_count;

    `LPC_ASSERT_IMPL(a_hit_no_transfer, clk, rst_n, !empty && hit, !load_request && !writeback_request)
    `LPC_ASSERT_IMPL(a_flush_word_clean, clk, rst_n, !empty && !last, !hit && !load_request)
    `LPC_ASSERT_NEXT(a_faults_grow, clk, rst_n, !empty && pop, empty || fault_count >= $past(fault_count))

endmodule

`default_nettype wire

// ===== sv/lpc_fifo.sv =====
// ----------------------------------------------------------------------------
// LRU page cache controller word queue
// Small register queue with push/full and pop/empty handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module lpc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = lpc_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] rd_data,
    output logic                  empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// ===== sv/lpc_front.sv =====
// ----------------------------------------------------------------------------
// LRU page cache controller front end
// Accepts input words, decodes the operation, splits the element index into
// page and offset, and queues the command for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module lpc_front #(
    parameter int INDEX_BITS  = lpc_pkg::INDEX_BITS_DEF,
    parameter int QUEUE_DEPTH = lpc_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    output logic                       full,
    input  wire logic                  op,
    input  wire logic [INDEX_BITS-1:0] element_index,
    output lpc_pkg::cmd_t              cmd,
    output logic                       cmd_valid,
    input  wire logic                  cmd_take
);

    localparam int SPLIT_W = lpc_pkg::OFFS_W + lpc_pkg::TAG_W;
    localparam int EXT_W   = (INDEX_BITS > SPLIT_W) ? INDEX_BITS : SPLIT_W;
    localparam int CMD_W   = $bits(lpc_pkg::cmd_t);

    logic [EXT_W-1:0]    idx_ext;
    lpc_pkg::cmd_t       cmd_in;
    logic [CMD_W-1:0]    cmd_word;
    logic                cmd_empty;

    always_comb
    begin
        idx_ext = '0;
        idx_ext[INDEX_BITS-1:0] = element_index;
        cmd_in.flush  = (op == lpc_pkg::OP_FLUSH);
        cmd_in.page   = idx_ext[lpc_pkg::OFFS_W +: lpc_pkg::TAG_W];
        cmd_in.offset = idx_ext[lpc_pkg::OFFS_W-1:0];
    end

    lpc_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (cmd_in),
        .full    (full),
        .pop     (cmd_take),
        .rd_data (cmd_word),
        .empty   (cmd_empty)
    );

    assign cmd       = lpc_pkg::cmd_t'(cmd_word);
    assign cmd_valid = !cmd_empty;

endmodule

`default_nettype wire

// ===== sv/lpc_back.sv =====
// ----------------------------------------------------------------------------
// LRU page cache controller back end
// Holds the frame tags, dirty marks, recency ranks and counters, carries out
// accesses and steps through the frames on a flush.
// ----------------------------------------------------------------------------
`default_nettype none

module lpc_back #(
    parameter int FRAME_COUNT = lpc_pkg::FRAME_COUNT_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire lpc_pkg::cmd_t     cmd,
    input  wire logic              cmd_valid,
    output logic                   cmd_take,
    input  wire logic              res_full,
    output logic                   res_valid,
    output lpc_pkg::res_t          res,
    output logic [$clog2(FRAME_COUNT)-1:0] res_slot
);

    localparam int SLOT_W = $clog2(FRAME_COUNT);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(FRAME_COUNT - 1);

    logic [lpc_pkg::TAG_W-1:0]   tag_reg   [FRAME_COUNT];
    logic [lpc_pkg::TAG_W-1:0]   tag_next  [FRAME_COUNT];
    logic [SLOT_W-1:0]           rank_reg  [FRAME_COUNT];
    logic [SLOT_W-1:0]           rank_next [FRAME_COUNT];
    logic [FRAME_COUNT-1:0]      dirty_reg, dirty_next;
    logic [lpc_pkg::COUNT_W-1:0] hits_reg, hits_next;
    logic [lpc_pkg::COUNT_W-1:0] faults_reg, faults_next;
    logic [SLOT_W-1:0]           flush_slot_reg, flush_slot_next;

    logic                        step;
    logic                        hit_any;
    logic [SLOT_W-1:0]           hit_slot;
    logic [SLOT_W-1:0]           victim;
    logic [SLOT_W-1:0]           sel;
    logic [SLOT_W-1:0]           sel_rank;
    logic                        flush_dirty;

    assign step = cmd_valid && !res_full;

    always_comb
    begin
        hit_any  = 1'b0;
        hit_slot = '0;
        victim   = '0;
        for (int i = FRAME_COUNT - 1; i >= 0; i--)
        begin
            if (tag_reg[i] == cmd.page)
            begin
                hit_any  = 1'b1;
                hit_slot = SLOT_W'(i);
            end
            if (rank_reg[i] == '0)
            begin
                victim = SLOT_W'(i);
            end
        end
        sel         = hit_any ? hit_slot : victim;
        sel_rank    = rank_reg[sel];
        flush_dirty = dirty_reg[flush_slot_reg];
    end

    always_comb
    begin
        tag_next        = tag_reg;
        rank_next       = rank_reg;
        dirty_next      = dirty_reg;
        hits_next       = hits_reg;
        faults_next     = faults_reg;
        flush_slot_next = flush_slot_reg;
        cmd_take        = 1'b0;

        if (step && cmd.flush)
        begin
            dirty_next[flush_slot_reg] = 1'b0;
            if (flush_slot_reg == LAST_SLOT)
            begin
                flush_slot_next = '0;
                cmd_take        = 1'b1;
            end
            else
            begin
                flush_slot_next = flush_slot_reg + 1'b1;
            end
        end
        else if (step)
        begin
            cmd_take = 1'b1;
            if (hit_any)
            begin
                if (hits_reg != '1)
                begin
                    hits_next = hits_reg + 1'b1;
                end
            end
            else
            begin
                if (faults_reg != '1)
                begin
                    faults_next = faults_reg + 1'b1;
                end
                tag_next[sel] = cmd.page;
            end
            for (int i = 0; i < FRAME_COUNT; i++)
            begin
                if (rank_reg[i] > sel_rank)
                begin
                    rank_next[i] = rank_reg[i] - 1'b1;
                end
            end
            rank_next[sel]  = LAST_SLOT;
            dirty_next[sel] = 1'b1;
        end
    end

    always_comb
    begin
        res_valid = step;
        res.hit_count   = hits_next;
        res.fault_count = faults_next;
        if (cmd.flush)
        begin
            res_slot              = flush_slot_reg;
            res.last              = (flush_slot_reg == LAST_SLOT);
            res.hit               = 1'b0;
            res.page_offset       = '0;
            res.load_request      = 1'b0;
            res.load_page         = '0;
            res.writeback_request = flush_dirty;
            res.writeback_page    = flush_dirty ? tag_reg[flush_slot_reg] : '0;
        end
        else
        begin
            res_slot              = sel;
            res.last              = 1'b1;
            res.hit               = hit_any;
            res.page_offset       = cmd.offset;
            res.load_request      = !hit_any;
            res.load_page         = hit_any ? '0 : cmd.page;
            res.writeback_request = !hit_any && dirty_reg[sel];
            res.writeback_page    = (!hit_any && dirty_reg[sel]) ? tag_reg[sel] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < FRAME_COUNT; i++)
            begin
                tag_reg[i]  <= lpc_pkg::TAG_W'(i);
                rank_reg[i] <= SLOT_W'(i);
            end
            dirty_reg      <= '0;
            hits_reg       <= '0;
            faults_reg     <= '0;
            flush_slot_reg <= '0;
        end
        else
        begin
            tag_reg        <= tag_next;
            rank_reg       <= rank_next;
            dirty_reg      <= dirty_next;
            hits_reg       <= hits_next;
            faults_reg     <= faults_next;
            flush_slot_reg <= flush_slot_next;
        end
    end

endmodule

`default_nettype wire
